// ----- rtl/pat_pkg.sv -----
package pat_pkg;

  localparam int SEQ_BITS   = 16;
  localparam int LOG_DEPTH  = 256;
  localparam int SLOT_BITS  = $clog2(LOG_DEPTH);
  localparam int ACK_WINDOW = 32;
  localparam int WIN_BITS   = $clog2(ACK_WINDOW);
  localparam int TIME_BITS  = 32;
  localparam int CFG_BITS   = 16;

  localparam logic [SEQ_BITS-1:0] SEQ_HALF = SEQ_BITS'(1) << (SEQ_BITS - 1);

  typedef enum logic [1:0] {
    ACT_SEND  = 2'd0,
    ACT_RECV  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CFG_START_SEQ = 2'd0,
    CFG_INIT_RTT  = 2'd1,
    CFG_RTT_GAIN  = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  typedef enum logic [10:0] {
    S_INIT    = 11'b00000000001,
    S_IDLE    = 11'b00000000010,
    S_CLR     = 11'b00000000100,
    S_RECV    = 11'b00000001000,
    S_GAP     = 11'b00000010000,
    S_LOG     = 11'b00000100000,
    S_ACK_RD  = 11'b00001000000,
    S_ACK_CHK = 11'b00010000000,
    S_SMOOTH  = 11'b00100000000,
    S_BMAP    = 11'b01000000000,
    S_DONE    = 11'b10000000000
  } state_t;

  // a is newer than b under wrapping sequence order
  function automatic logic seq_newer(input logic [SEQ_BITS-1:0] a,
                                     input logic [SEQ_BITS-1:0] b);
    logic [SEQ_BITS-1:0] d;
    d = a - b;
    return ((d != '0) && (d < SEQ_HALF)) || ((d == SEQ_HALF) && (a > b));
  endfunction

endpackage

// ----- rtl/pat_ram.sv -----
module pat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/pat_smooth.sv -----
// RTT smoothing: three stages, diff, multiply, round and saturate
module pat_smooth (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] rtt_in,
  input  logic [31:0] smooth_in,
  input  logic [15:0] gain,
  output logic        done,
  output logic [31:0] smooth_out
);

  logic               v0, v1;
  logic signed [40:0] diff;
  logic [15:0]        g0;
  logic [31:0]        sm0, sm1;
  logic signed [57:0] prod;
  logic signed [57:0] rnd_pos, rnd_neg, delta, n;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v0   <= start;
      v1   <= v0;
      done <= v1;
    end
  end

  always_ff @(posedge clk) begin
    diff <= $signed({1'b0, rtt_in, 8'b0}) - $signed({9'b0, smooth_in});
    sm0  <= smooth_in;
    g0   <= gain;
    prod <= 58'(diff * $signed({1'b0, g0}));
    sm1  <= sm0;
    if (v1) begin
      if (n < 0) begin
        smooth_out <= '0;
      end else if (n > $signed({26'b0, 32'hFFFF_FFFF})) begin
        smooth_out <= 32'hFFFF_FFFF;
      end else begin
        smooth_out <= n[31:0];
      end
    end
  end

  // round to nearest, ties away from zero
  always_comb begin
    rnd_pos = (prod + 58'sd32768) >>> 16;
    rnd_neg = -((-prod + 58'sd32768) >>> 16);
    delta   = (prod >= 0) ? rnd_pos : rnd_neg;
    n       = $signed({26'b0, sm1}) + delta;
  end

endmodule

// ----- rtl/packet_ack_tracker_core.sv -----
// Channel | Signals                                          | Dir
// config  | cfg_we, cfg_index, cfg_data                      | in
// input   | in_valid/in_ready, action, sequence_req,         | in
//         | ack_number, ack_bits, now_ms                     |
// result  | out_valid/out_ready, seq_id, ack_out,            | out
//         | ack_bits_out, newly_acked, stale, last_rtt,      |
//         | smoothed_rtt                                     |
//
// One transaction at a time. Send and ignored actions: accept, bitmap
// walk, result. Stale receive: accept, bitmap walk, result. Clear:
// accept, sweep of both logs, result. Receive: accept, sweep of the
// skipped slots (whole receive log for a large gap), ack walk (read per
// ack bit, check per set bit, smoothing wait per new ack), bitmap walk,
// result. Reset (rst, synchronous) starts a sweep that invalidates
// every log entry; in_ready stays low until it ends. A result waits in
// done while out_valid is high and out_ready low; no input is taken then.
module packet_ack_tracker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] sequence_req,
  input  logic [15:0] ack_number,
  input  logic [31:0] ack_bits,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] seq_id,
  output logic [15:0] ack_out,
  output logic [31:0] ack_bits_out,
  output logic [31:0] newly_acked,
  output logic        stale,
  output logic [31:0] last_rtt,
  output logic [31:0] smoothed_rtt
);

  localparam int SB = pat_pkg::SEQ_BITS;
  localparam int KB = pat_pkg::SLOT_BITS;
  localparam int WB = pat_pkg::WIN_BITS;
  localparam int TB = pat_pkg::TIME_BITS;
  localparam int SW = 2 + SB + TB;  // sent entry: valid, acked, tag, time
  localparam int RW = 1 + SB;       // receive entry: valid, tag

  pat_pkg::state_t state;

  // configuration
  logic [15:0] start_sequence, initial_rtt, rtt_gain;

  // tracker state
  logic [SB-1:0] local_head, remote_head;
  logic [31:0] rtt_last, rtt_smooth;

  // per-transaction working registers
  logic [SB-1:0] req_seq, req_ack;
  logic [31:0]   req_bits, req_now;
  logic [SB-1:0] res_seq_id;
  logic [31:0]   res_newly, bitmap;
  logic          res_stale;
  logic [KB-1:0] sweep_addr;
  logic [KB:0]   sweep_left;
  logic [WB-1:0] ack_idx, bm_prev;
  logic [SB-1:0] ack_seq, bm_seq;
  logic [WB:0]   bm_cnt;

  // RAM ports
  logic               sent_we, recv_we;
  logic [KB-1:0]      sent_waddr, sent_raddr, recv_waddr, recv_raddr;
  logic [SW-1:0]      sent_wdata, sent_rdata;
  logic [RW-1:0]      recv_wdata, recv_rdata;

  // smoothing unit
  logic        sm_start, sm_done;
  logic [31:0] sm_out, rtt_new;

  logic [SB-1:0] floor_seq, gap;
  logic          ack_hit, in_fire, res_load, sweep_all;
  logic [SB-1:0] bm_addr_seq, ack_rd_seq;

  assign in_ready = (state == pat_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign floor_seq   = remote_head - SB'(pat_pkg::LOG_DEPTH);
  assign gap         = req_seq - remote_head - SB'(1);
  assign rtt_new     = req_now - sent_rdata[TB-1:0];
  assign bm_addr_seq = remote_head - SB'(bm_cnt[WB-1:0]);
  assign ack_rd_seq  = req_ack - SB'(ack_idx);
  // hit: entry valid, not yet acked, and tagged with this sequence
  assign ack_hit     = sent_rdata[SW-1] && !sent_rdata[SW-2] &&
                       (sent_rdata[SB+TB-1:TB] == ack_seq);

  always_comb begin
    res_load   = (state == pat_pkg::S_DONE) && (!out_valid || out_ready);
    sweep_all  = (state == pat_pkg::S_INIT) || (state == pat_pkg::S_CLR);
    sent_raddr = ack_rd_seq[KB-1:0];
    if (sweep_all) begin
      sent_we    = 1'b1;
      sent_waddr = sweep_addr;
      sent_wdata = '0;
    end else if (state == pat_pkg::S_ACK_CHK) begin
      // mark the entry acked, keep tag and send time
      sent_we    = ack_hit;
      sent_waddr = ack_seq[KB-1:0];
      sent_wdata = {1'b1, 1'b1, ack_seq, sent_rdata[TB-1:0]};
    end else begin
      sent_we    = in_fire && (pat_pkg::action_t'(action) == pat_pkg::ACT_SEND);
      sent_waddr = local_head[KB-1:0];
      sent_wdata = {1'b1, 1'b0, local_head, now_ms};
    end
    recv_we    = sweep_all || (state == pat_pkg::S_GAP) || (state == pat_pkg::S_LOG);
    recv_waddr = (state == pat_pkg::S_LOG) ? req_seq[KB-1:0] : sweep_addr;
    recv_wdata = (state == pat_pkg::S_LOG) ? {1'b1, req_seq} : '0;
    recv_raddr = bm_addr_seq[KB-1:0];
    sm_start   = (state == pat_pkg::S_ACK_CHK) && ack_hit;
  end

  pat_ram #(.WIDTH(SW), .DEPTH(pat_pkg::LOG_DEPTH)) u_sent_log (
    .clk(clk), .we(sent_we), .waddr(sent_waddr), .wdata(sent_wdata),
    .raddr(sent_raddr), .rdata(sent_rdata)
  );

  pat_ram #(.WIDTH(RW), .DEPTH(pat_pkg::LOG_DEPTH)) u_recv_log (
    .clk(clk), .we(recv_we), .waddr(recv_waddr), .wdata(recv_wdata),
    .raddr(recv_raddr), .rdata(recv_rdata)
  );

  pat_smooth u_smooth (
    .clk(clk), .rst(rst), .start(sm_start), .rtt_in(rtt_new),
    .smooth_in(rtt_smooth), .gain(rtt_gain), .done(sm_done), .smooth_out(sm_out)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_sequence <= 16'd0;
      initial_rtt    <= 16'd30;
      rtt_gain       <= 16'd1638;
    end else if (cfg_we) begin
      unique case (pat_pkg::cfg_idx_t'(cfg_index))
        pat_pkg::CFG_START_SEQ: start_sequence <= cfg_data;
        pat_pkg::CFG_INIT_RTT:  initial_rtt    <= cfg_data;
        pat_pkg::CFG_RTT_GAIN:  rtt_gain       <= cfg_data;
        default: ;
      endcase
    end
  end

  // result valid: set on load, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer and tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pat_pkg::S_INIT;
      sweep_addr  <= '0;
      sweep_left  <= (KB+1)'(pat_pkg::LOG_DEPTH);
      local_head  <= SB'(16'd0);
      remote_head <= SB'(16'd0) - SB'(1);
      rtt_last    <= 32'd30;
      rtt_smooth  <= 32'd30 << 8;
    end else begin
      unique case (state)
        pat_pkg::S_INIT: begin
          // invalidate both logs, one entry a cycle
          sweep_addr <= sweep_addr + KB'(1);
          sweep_left <= sweep_left - (KB+1)'(1);
          if (sweep_left == (KB+1)'(1)) begin
            state <= pat_pkg::S_IDLE;
          end
        end
        pat_pkg::S_IDLE: begin
          if (in_fire) begin
            req_seq    <= sequence_req[SB-1:0];
            req_ack    <= ack_number[SB-1:0];
            req_bits   <= ack_bits;
            req_now    <= now_ms;
            res_seq_id <= '0;
            res_newly  <= '0;
            res_stale  <= 1'b0;
            bm_cnt     <= '0;
            bitmap     <= '0;
            state      <= pat_pkg::S_BMAP;
            unique case (pat_pkg::action_t'(action))
              pat_pkg::ACT_SEND: begin
                res_seq_id <= local_head;
                local_head <= local_head + SB'(1);
              end
              pat_pkg::ACT_RECV: begin
                state <= pat_pkg::S_RECV;
              end
              pat_pkg::ACT_CLEAR: begin
                local_head  <= start_sequence[SB-1:0];
                remote_head <= start_sequence[SB-1:0] - SB'(1);
                rtt_last    <= {16'd0, initial_rtt};
                rtt_smooth  <= {8'd0, initial_rtt, 8'd0};
                sweep_addr  <= '0;
                sweep_left  <= (KB+1)'(pat_pkg::LOG_DEPTH);
                state       <= pat_pkg::S_CLR;
              end
              default: ;
            endcase
          end
        end
        pat_pkg::S_CLR: begin
          // both logs empty afterwards, so the bitmap stays zero
          sweep_addr <= sweep_addr + KB'(1);
          sweep_left <= sweep_left - (KB+1)'(1);
          if (sweep_left == (KB+1)'(1)) begin
            state <= pat_pkg::S_DONE;
          end
        end
        pat_pkg::S_RECV: begin
          if (pat_pkg::seq_newer(floor_seq, req_seq)) begin
            res_stale <= 1'b1;
            state     <= pat_pkg::S_BMAP;
          end else if (pat_pkg::seq_newer(req_seq, remote_head)) begin
            remote_head <= req_seq;
            sweep_addr  <= KB'(remote_head + SB'(1));
            if (gap >= SB'(pat_pkg::LOG_DEPTH)) begin
              // large gap: sweep the whole receive log
              sweep_left <= (KB+1)'(pat_pkg::LOG_DEPTH);
              state      <= pat_pkg::S_GAP;
            end else if (gap != '0) begin
              sweep_left <= gap[KB:0];
              state      <= pat_pkg::S_GAP;
            end else begin
              state <= pat_pkg::S_LOG;
            end
          end else begin
            state <= pat_pkg::S_LOG;
          end
        end
        pat_pkg::S_GAP: begin
          sweep_addr <= sweep_addr + KB'(1);
          sweep_left <= sweep_left - (KB+1)'(1);
          if (sweep_left == (KB+1)'(1)) begin
            state <= pat_pkg::S_LOG;
          end
        end
        pat_pkg::S_LOG: begin
          ack_idx <= '0;
          state   <= pat_pkg::S_ACK_RD;
        end
        pat_pkg::S_ACK_RD: begin
          ack_seq <= ack_rd_seq;
          if (req_bits[ack_idx]) begin
            state <= pat_pkg::S_ACK_CHK;
          end else if (ack_idx == WB'(pat_pkg::ACK_WINDOW - 1)) begin
            state <= pat_pkg::S_BMAP;
          end else begin
            ack_idx <= ack_idx + WB'(1);
          end
        end
        pat_pkg::S_ACK_CHK: begin
          if (ack_hit) begin
            res_newly[ack_idx] <= 1'b1;
            rtt_last           <= rtt_new;
            state              <= pat_pkg::S_SMOOTH;
          end else if (ack_idx == WB'(pat_pkg::ACK_WINDOW - 1)) begin
            state <= pat_pkg::S_BMAP;
          end else begin
            ack_idx <= ack_idx + WB'(1);
            state   <= pat_pkg::S_ACK_RD;
          end
        end
        pat_pkg::S_SMOOTH: begin
          if (sm_done) begin
            rtt_smooth <= sm_out;
            if (ack_idx == WB'(pat_pkg::ACK_WINDOW - 1)) begin
              state <= pat_pkg::S_BMAP;
            end else begin
              ack_idx <= ack_idx + WB'(1);
              state   <= pat_pkg::S_ACK_RD;
            end
          end
        end
        pat_pkg::S_BMAP: begin
          // read issued for entry bm_cnt, compare for entry bm_cnt-1
          bm_seq  <= bm_addr_seq;
          bm_prev <= bm_cnt[WB-1:0];
          bm_cnt  <= bm_cnt + (WB+1)'(1);
          if (bm_cnt != '0) begin
            bitmap[bm_prev] <= (recv_rdata == {1'b1, bm_seq});
          end
          if (bm_cnt == (WB+1)'(pat_pkg::ACK_WINDOW)) begin
            state <= pat_pkg::S_DONE;
          end
        end
        pat_pkg::S_DONE: begin
          if (res_load) begin
            seq_id       <= 16'(res_seq_id);
            ack_out      <= 16'(remote_head);
            ack_bits_out <= bitmap;
            newly_acked  <= res_newly;
            stale        <= res_stale;
            last_rtt     <= rtt_last;
            smoothed_rtt <= rtt_smooth;
            state        <= pat_pkg::S_IDLE;
          end
        end
        default: state <= pat_pkg::S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/pat_checker.sv -----
module pat_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] newly_acked,
  input logic        stale
);

  // one transaction at a time: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(newly_acked) && $stable(stale))
    else $error("result dropped or changed while stalled");

  a_stale_no_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && stale |-> newly_acked == '0)
    else $error("stale receive reported acks");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after accept");

endmodule

bind packet_ack_tracker_core pat_checker u_pat_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .newly_acked(newly_acked), .stale(stale)
);
